/* rtl/ecb_pkg.sv */
// shared types, constants and fixed-point helpers for the camera basis block
`default_nettype none
package ecb_pkg;

  localparam int Q = 30;
  localparam int ANGLE_BITS = 16;
  localparam int FRACTION_BITS = 14;
  localparam int CELL_CNT = 6;
  // front end, horner cells of three stages, final sine product, basis stages
  localparam int LATENCY = 3 + 3 * CELL_CNT + 1 + 3;

  localparam logic [30:0] ONE_Q = 31'd1 << Q;
  localparam logic [63:0] TWO_PI_Q40 = 64'h6487ED5110B;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QUARTER_R = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] EIGHTH_R = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 3);

  // series denominators in horner order, a zero marks a pass-through cell
  localparam logic [7:0] SIN_DEN [CELL_CNT] = '{8'd0, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DEN [CELL_CNT] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  // floor(2^32 / den)
  localparam logic [31:0] SIN_RCP [CELL_CNT] = '{32'd0, 32'd39045157, 32'd59652323,
                                                  32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_RCP [CELL_CNT] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                                  32'd143165576, 32'd357913941, 32'd2147483648};

  // word handed from cell to cell
  typedef struct packed {
    logic        neg;
    logic        cos_mode;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] p;
  } hword_t;

  // q30 product rounded half away from zero
  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] m;
    begin
      neg = a[31] ^ b[31];
      ma = a[31] ? 32'(-a) : 32'(a);
      mb = b[31] ? 32'(-b) : 32'(b);
      m = ((64'(ma) * 64'(mb)) + (64'd1 << (Q - 1))) >> Q;
      mul_q = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
    end
  endfunction

  // q30 to output fraction bits, rounded, clamped and cut to 16 bits
  function automatic logic [15:0] narrow(input logic signed [33:0] v);
    logic        neg;
    logic [33:0] m;
    logic [33:0] lim;
    begin
      neg = v[33];
      m = neg ? 34'(-v) : 34'(v);
      lim = 34'd1 << FRACTION_BITS;
      m = (m + (34'd1 << (Q - FRACTION_BITS - 1))) >> (Q - FRACTION_BITS);
      if (m > lim) begin
        m = lim;
      end
      narrow = neg ? 16'(-m) : m[15:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/ecb_cell.sv */
// one horner step of the sine or cosine series, three stages deep
`default_nettype none
module ecb_cell import ecb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire hword_t      d_in,
  input  wire logic [7:0]  sin_den,
  input  wire logic [31:0] sin_rcp,
  input  wire logic [7:0]  cos_den,
  input  wire logic [31:0] cos_rcp,
  output hword_t           d_out
);

  hword_t      s1_r, s2_r, s3_r;
  logic [60:0] prod_r;
  logic [30:0] n_r;
  logic [30:0] q0_r;

  logic [7:0]  den2, den3;
  logic [31:0] rcp2;
  logic [63:0] n_full;
  logic [30:0] n_nxt;
  logic [62:0] nm;
  logic [38:0] qd;
  logic [31:0] rem;
  logic [30:0] q;
  hword_t      s3_nxt;

  // denominator for the word in each stage
  assign den2 = s1_r.cos_mode ? cos_den : sin_den;
  assign rcp2 = s1_r.cos_mode ? cos_rcp : sin_rcp;
  assign den3 = s2_r.cos_mode ? cos_den : sin_den;

  // rounded numerator and reciprocal estimate
  always_comb begin
    n_full = 64'(prod_r) + (64'(den2) << (Q - 1));
    n_nxt = n_full[60:30];
    nm = 63'(n_nxt) * 63'(rcp2);
  end

  // one-step correction of the quotient
  always_comb begin
    qd = 39'(q0_r) * 39'(den3);
    rem = {1'b0, n_r} - qd[31:0];
    q = q0_r + ((rem >= {24'd0, den3}) ? 31'd1 : 31'd0);
    s3_nxt = s2_r;
    if (s2_r.cos_mode || (sin_den != 8'd0)) begin
      s3_nxt.p = ONE_Q - q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= d_in;
      prod_r <= 61'(d_in.x2) * 61'(d_in.p);
      s2_r <= s1_r;
      n_r <= n_nxt;
      q0_r <= nm[62:32];
      s3_r <= s3_nxt;
    end
  end

  assign d_out = s3_r;

endmodule
`default_nettype wire

/* rtl/ecb_lane.sv */
// sine of one binary angle: octant reduction, radians, a row of horner cells
`default_nettype none
module ecb_lane import ecb_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [ANGLE_BITS-1:0]  angle,
  output logic signed [31:0]          value
);

  logic [ANGLE_BITS-3:0] t_r;
  logic                  cos0_r, neg0_r;
  hword_t                f1_r, f2_r;
  hword_t                chain [CELL_CNT+1];
  logic signed [31:0]    value_r;

  logic [ANGLE_BITS-2:0] r;
  logic [ANGLE_BITS-2:0] t_full;
  logic                  use_cos;
  logic [63:0]           xp;
  logic [63:0]           x2p;
  hword_t                f2_nxt;
  logic [63:0]           sp;
  logic [30:0]           mag;

  // quadrant and octant reduction
  always_comb begin
    r = {1'b0, angle[ANGLE_BITS-3:0]};
    if (angle[ANGLE_BITS-2]) begin
      r = QUARTER_R - r;
    end
    use_cos = (r > EIGHTH_R);
    t_full = use_cos ? (QUARTER_R - r) : r;
  end

  // radians and their square
  always_comb begin
    xp = (64'(t_r) * TWO_PI_Q40 + (64'd1 << (ANGLE_BITS + 9))) >> (ANGLE_BITS + 10);
    x2p = (64'(f1_r.x) * 64'(f1_r.x) + (64'd1 << (Q - 1))) >> Q;
    f2_nxt = f1_r;
    f2_nxt.x2 = x2p[29:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_full[ANGLE_BITS-3:0];
      cos0_r <= use_cos;
      neg0_r <= angle[ANGLE_BITS-1];
      f1_r.neg <= neg0_r;
      f1_r.cos_mode <= cos0_r;
      f1_r.x <= xp[29:0];
      f1_r.x2 <= '0;
      f1_r.p <= ONE_Q;
      f2_r <= f2_nxt;
    end
  end

  assign chain[0] = f2_r;

  // row of horner cells
  for (genvar k = 0; k < CELL_CNT; k++) begin : g_cell
    ecb_cell u_cell (
      .clk     (clk),
      .en      (en),
      .d_in    (chain[k]),
      .sin_den (SIN_DEN[k]),
      .sin_rcp (SIN_RCP[k]),
      .cos_den (COS_DEN[k]),
      .cos_rcp (COS_RCP[k]),
      .d_out   (chain[k+1])
    );
  end

  // sine series takes a final factor of x, then the quadrant sign
  always_comb begin
    sp = (64'(chain[CELL_CNT].x) * 64'(chain[CELL_CNT].p) + (64'd1 << (Q - 1))) >> Q;
    mag = chain[CELL_CNT].cos_mode ? chain[CELL_CNT].p : sp[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= chain[CELL_CNT].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign value = value_r;

endmodule
`default_nettype wire

/* rtl/ecb_basis.sv */
// front, right and up vectors from the six sines and cosines, three stages
`default_nettype none
module ecb_basis import ecb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] sy,
  input  wire logic signed [31:0] cp,
  input  wire logic signed [31:0] sp,
  input  wire logic signed [31:0] cr,
  input  wire logic signed [31:0] sr,
  output logic [15:0]             front_x,
  output logic [15:0]             front_y,
  output logic [15:0]             front_z,
  output logic [15:0]             right_x,
  output logic [15:0]             right_y,
  output logic [15:0]             right_z,
  output logic [15:0]             up_x,
  output logic [15:0]             up_y,
  output logic [15:0]             up_z,
  output logic                    degenerate
);

  logic signed [31:0] cy_r, sy_r, cp_r, sp_r, cr_r, sr_r;
  logic signed [31:0] cycp_r, sycp_r, cysp_r, sysp_r;
  logic signed [31:0] crbr0_r, srbu0_r, crbu0_r, srbr0_r;
  logic signed [31:0] srbu1_r, crbu1_r;
  logic signed [31:0] crbr2_r, srbu2_r, crbu2_r, srbr2_r;
  logic [15:0]        fx_r, fy_r, fz_r, fx2_r, fy2_r, fz2_r;
  logic               dg_r, dg2_r;
  logic [15:0]        rx_r, ry_r, rz_r, ux_r, uy_r, uz_r;

  logic               sneg;
  logic signed [31:0] br0, br2, bu0, bu1, bu2;

  // unrolled basis, sign taken from cos pitch
  always_comb begin
    sneg = cp_r[31];
    br0 = sneg ? sy_r : -sy_r;
    br2 = sneg ? -cy_r : cy_r;
    bu0 = sneg ? cysp_r : -cysp_r;
    bu1 = sneg ? -cp_r : cp_r;
    bu2 = sneg ? sysp_r : -sysp_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // yaw by pitch products
      cy_r <= cy;
      sy_r <= sy;
      cp_r <= cp;
      sp_r <= sp;
      cr_r <= cr;
      sr_r <= sr;
      cycp_r <= mul_q(cy, cp);
      sycp_r <= mul_q(sy, cp);
      cysp_r <= mul_q(cy, sp);
      sysp_r <= mul_q(sy, sp);
      // roll products and front narrowing
      crbr0_r <= mul_q(cr_r, br0);
      srbu0_r <= mul_q(sr_r, bu0);
      crbu0_r <= mul_q(cr_r, bu0);
      srbr0_r <= mul_q(sr_r, br0);
      srbu1_r <= mul_q(sr_r, bu1);
      crbu1_r <= mul_q(cr_r, bu1);
      crbr2_r <= mul_q(cr_r, br2);
      srbu2_r <= mul_q(sr_r, bu2);
      crbu2_r <= mul_q(cr_r, bu2);
      srbr2_r <= mul_q(sr_r, br2);
      fx_r <= narrow(34'(cycp_r));
      fy_r <= narrow(34'(sp_r));
      fz_r <= narrow(34'(sycp_r));
      dg_r <= (cp_r == 32'sd0);
      // sums, degenerate zeroing and output narrowing
      fx2_r <= fx_r;
      fy2_r <= fy_r;
      fz2_r <= fz_r;
      dg2_r <= dg_r;
      rx_r <= dg_r ? 16'd0 : narrow(34'(crbr0_r) + 34'(srbu0_r));
      ry_r <= dg_r ? 16'd0 : narrow(34'(srbu1_r));
      rz_r <= dg_r ? 16'd0 : narrow(34'(crbr2_r) + 34'(srbu2_r));
      ux_r <= dg_r ? 16'd0 : narrow(34'(crbu0_r) - 34'(srbr0_r));
      uy_r <= dg_r ? 16'd0 : narrow(34'(crbu1_r));
      uz_r <= dg_r ? 16'd0 : narrow(34'(crbu2_r) - 34'(srbr2_r));
    end
  end

  assign front_x = fx2_r;
  assign front_y = fy2_r;
  assign front_z = fz2_r;
  assign right_x = rx_r;
  assign right_y = ry_r;
  assign right_z = rz_r;
  assign up_x = ux_r;
  assign up_y = uy_r;
  assign up_z = uz_r;
  assign degenerate = dg2_r;

endmodule
`default_nettype wire

/* rtl/euler_camera_basis_unit.sv */
// Camera basis from binary Euler angles.
// The input channel takes one word of yaw, pitch and roll (65536 units per
// turn) on in_valid/in_ready. The result channel gives the front, right and
// up vectors in signed Q1.14 and a degenerate flag on out_valid/out_ready.
// Each angle feeds two lanes (sine and cosine). A lane reduces the angle to
// an octant, converts it to radians and runs a row of six horner cells, each
// three stages deep; a basis unit then forms the products and the roll.
// The pipeline is 25 stages; out_valid rises when a word reaches the last.
// One word is accepted per cycle while the pipeline advances; throughput
// is one result per clock while out_ready is high.
// The whole pipeline advances together: while a result waits on a low
// out_ready everything holds, and in_ready is low for that time. A stage
// whose word is empty still holds nothing of value, so no result is lost.
// Reset clears all valid flags; no result is shown until new words arrive.
// Pitch of exactly a quarter or three quarters of a turn raises degenerate
// with right and up all zero.
`default_nettype none
module euler_camera_basis_unit import ecb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_yaw_angle,
  input  wire logic [15:0] in_pitch_angle,
  input  wire logic [15:0] in_roll_angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_front_x,
  output logic [15:0]      out_front_y,
  output logic [15:0]      out_front_z,
  output logic [15:0]      out_right_x,
  output logic [15:0]      out_right_y,
  output logic [15:0]      out_right_z,
  output logic [15:0]      out_up_x,
  output logic [15:0]      out_up_y,
  output logic [15:0]      out_up_z,
  output logic             out_degenerate
);

  logic               en;
  logic [LATENCY-1:0] vld_r;
  logic signed [31:0] cy, sy, cp, sp, cr, sr;

  // pipeline advance
  assign en = !vld_r[LATENCY-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[LATENCY-1];

  // valid flags follow the words down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LATENCY-2:0], in_valid};
    end
  end

  // sine and cosine lanes
  ecb_lane u_cy (.clk(clk), .en(en), .angle(in_yaw_angle + QUARTER_TURN), .value(cy));
  ecb_lane u_sy (.clk(clk), .en(en), .angle(in_yaw_angle), .value(sy));
  ecb_lane u_cp (.clk(clk), .en(en), .angle(in_pitch_angle + QUARTER_TURN), .value(cp));
  ecb_lane u_sp (.clk(clk), .en(en), .angle(in_pitch_angle), .value(sp));
  ecb_lane u_cr (.clk(clk), .en(en), .angle(in_roll_angle + QUARTER_TURN), .value(cr));
  ecb_lane u_sr (.clk(clk), .en(en), .angle(in_roll_angle), .value(sr));

  // basis and roll
  ecb_basis u_basis (
    .clk        (clk),
    .en         (en),
    .cy         (cy),
    .sy         (sy),
    .cp         (cp),
    .sp         (sp),
    .cr         (cr),
    .sr         (sr),
    .front_x    (out_front_x),
    .front_y    (out_front_y),
    .front_z    (out_front_z),
    .right_x    (out_right_x),
    .right_y    (out_right_y),
    .right_z    (out_right_z),
    .up_x       (out_up_x),
    .up_y       (out_up_y),
    .up_z       (out_up_z),
    .degenerate (out_degenerate)
  );

endmodule
`default_nettype wire

/* rtl/ecb_checker.sv */
// port-level checks for the camera basis block and their binding
`default_nettype none
module ecb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_front_x,
  input wire logic [15:0] out_front_z,
  input wire logic [15:0] out_right_x,
  input wire logic [15:0] out_right_y,
  input wire logic [15:0] out_right_z,
  input wire logic [15:0] out_up_x,
  input wire logic [15:0] out_up_y,
  input wire logic [15:0] out_up_z,
  input wire logic        out_degenerate
);

  // a waiting word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown after reset");

  // stalled output stops intake
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  // straight up or down has no right or up vector, and front x and z are zero
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_right_x == 16'd0 && out_right_y == 16'd0 &&
      out_right_z == 16'd0 && out_up_x == 16'd0 && out_up_y == 16'd0 &&
      out_up_z == 16'd0 && out_front_x == 16'd0 && out_front_z == 16'd0)
    else $error("degenerate word with nonzero basis");

endmodule

bind euler_camera_basis_unit ecb_checker u_ecb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_front_x    (out_front_x),
  .out_front_z    (out_front_z),
  .out_right_x    (out_right_x),
  .out_right_y    (out_right_y),
  .out_right_z    (out_right_z),
  .out_up_x       (out_up_x),
  .out_up_y       (out_up_y),
  .out_up_z       (out_up_z),
  .out_degenerate (out_degenerate)
);
`default_nettype wire

/* sim/tb_euler_camera_basis_unit.sv */
// testbench for the camera basis unit: directed and random angle words checked against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_euler_camera_basis_unit;
  import ecb_pkg::*;

  localparam int QB = 30;
  localparam int ABITS = 16;
  localparam int FBITS = 14;
  localparam longint unsigned QONE = 64'd1 << QB;
  localparam longint unsigned TWOPI_Q40 = 64'h6487ED5110B;
  localparam longint unsigned AMASK = (64'd1 << ABITS) - 1;
  localparam longint unsigned QTURN = 64'd1 << (ABITS - 2);
  localparam longint unsigned ETURN = 64'd1 << (ABITS - 3);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    logic        degen;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_yaw_angle = '0;
  logic [15:0] in_pitch_angle = '0;
  logic [15:0] in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_front_x, out_front_y, out_front_z;
  logic [15:0] out_right_x, out_right_y, out_right_z;
  logic [15:0] out_up_x, out_up_y, out_up_z;
  logic out_degenerate;

  basis_t expected_basis[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int degen_seen = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stall_on = 1'b0;

  euler_camera_basis_unit DUT (.*);

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results pending", $time, expected_basis.size());
      $display("[euler_camera_basis_unit] ERROR");
      $finish;
    end
  end

  // predictor: series kernels in unsigned q30
  function automatic longint unsigned series(longint unsigned x2, bit is_cos);
    longint unsigned p, d;
    longint unsigned dens[6];
    int n;
    if (is_cos) begin
      dens = '{2, 12, 30, 56, 90, 132};
      n = 6;
    end else begin
      dens = '{6, 20, 42, 72, 110, 0};
      n = 5;
    end
    p = QONE;
    for (int i = n - 1; i >= 0; i--) begin
      d = dens[i] << QB;
      p = QONE - (x2 * p + (d >> 1)) / d;
    end
    return p;
  endfunction

  function automatic longint unsigned octant_val(longint unsigned t, bit is_cos);
    longint unsigned x, x2;
    x = (t * TWOPI_Q40 + (64'd1 << (ABITS + 9))) >> (ABITS + 10);
    x2 = (x * x + (QONE >> 1)) >> QB;
    if (is_cos) return series(x2, 1'b1);
    return (x * series(x2, 1'b0) + (QONE >> 1)) >> QB;
  endfunction

  function automatic longint sine_of(longint unsigned a);
    longint unsigned quad, r, mag;
    quad = (a >> (ABITS - 2)) & 3;
    r = a & (QTURN - 1);
    if (quad[0]) r = QTURN - r;
    if (r <= ETURN) mag = octant_val(r, 1'b0);
    else mag = octant_val(QTURN - r, 1'b1);
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint cosine_of(longint unsigned a);
    return sine_of((a + QTURN) & AMASK);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = (ma * mb + (QONE >> 1)) >> QB;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (QB - FBITS - 1))) >> (QB - FBITS);
    if (m > (64'd1 << FBITS)) m = 64'd1 << FBITS;
    return v < 0 ? 16'(-m) : 16'(m);
  endfunction

  function automatic basis_t predict_basis(logic [15:0] yaw, logic [15:0] pitch,
                                           logic [15:0] roll);
    longint cy, sy, cp, sp, cr, sr, s;
    longint br[3], bu[3], r[3], u[3];
    basis_t b;
    cy = cosine_of(64'(yaw) & AMASK);
    sy = sine_of(64'(yaw) & AMASK);
    cp = cosine_of(64'(pitch) & AMASK);
    sp = sine_of(64'(pitch) & AMASK);
    cr = cosine_of(64'(roll) & AMASK);
    sr = sine_of(64'(roll) & AMASK);
    r = '{0, 0, 0};
    u = '{0, 0, 0};
    b.degen = (cp == 0);
    b.fx = to_q14(qmul(cy, cp));
    b.fy = to_q14(sp);
    b.fz = to_q14(qmul(sy, cp));
    if (!b.degen) begin
      s = cp > 0 ? 1 : -1;
      br = '{-s * sy, 0, s * cy};
      bu = '{-s * qmul(cy, sp), s * cp, -s * qmul(sy, sp)};
      for (int i = 0; i < 3; i++) begin
        r[i] = qmul(cr, br[i]) + qmul(sr, bu[i]);
        u[i] = qmul(cr, bu[i]) - qmul(sr, br[i]);
      end
    end
    b.rx = to_q14(r[0]); b.ry = to_q14(r[1]); b.rz = to_q14(r[2]);
    b.ux = to_q14(u[0]); b.uy = to_q14(u[1]); b.uz = to_q14(u[2]);
    return b;
  endfunction

  // send one word, gaps are left to the caller
  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    in_valid <= 1'b1;
    in_yaw_angle <= yaw;
    in_pitch_angle <= pitch;
    in_roll_angle <= roll;
    do @(posedge clk); while (!in_ready);
    expected_basis.push_back(predict_basis(yaw, pitch, roll));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if (stall_on) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  task automatic cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_basis.size() == 0) begin
        $display("%0t unexpected result word", $time);
        errors++;
      end else begin
        e = expected_basis.pop_front();
        words_checked++;
        if (e.degen) degen_seen++;
        cmp("front_x", e.fx, out_front_x);
        cmp("front_y", e.fy, out_front_y);
        cmp("front_z", e.fz, out_front_z);
        cmp("right_x", e.rx, out_right_x);
        cmp("right_y", e.ry, out_right_y);
        cmp("right_z", e.rz, out_right_z);
        cmp("up_x", e.ux, out_up_x);
        cmp("up_y", e.uy, out_up_y);
        cmp("up_z", e.uz, out_up_z);
        cmp("degenerate", 16'(e.degen), 16'(out_degenerate));
      end
    end
  end

  task automatic test_directed();
    logic [15:0] edges[8];
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000, 16'h2000, 16'h5555};
    // field extremes with zero roll
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i + 3) % 8], 16'h0000);
    // pitch straight up and down
    send_angles(16'h1234, 16'h4000, 16'h2000);
    send_angles(16'h8000, 16'hC000, 16'hFFFF);
    send_angles(16'h0000, 16'h4000, 16'h0000);
    // pitch beyond a quarter turn flips the right vector
    send_angles(16'h2000, 16'h6000, 16'h1000);
    send_angles(16'hE000, 16'hA000, 16'h7FFF);
    // octant boundaries
    send_angles(16'h2000, 16'h2001, 16'h1FFF);
    send_angles(16'h6000, 16'hDFFF, 16'h8001);
    send_angles(16'hFFFF, 16'h0001, 16'h8000);
  endtask

  task automatic test_random(int n);
    int burst;
    logic [15:0] p;
    stall_on = 1'b1;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        case ($urandom_range(0, 9))
          0: p = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
          1: p = 16'h4000 + 16'($urandom_range(0, 4)) - 16'd2;
          default: p = 16'($urandom);
        endcase
        send_angles(16'($urandom), p, $urandom_range(0, 7) == 0 ? 16'h0 : 16'($urandom));
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
    end
    stall_on = 1'b0;
  endtask

  task automatic test_backpressure();
    // long receiver hold-off while the sender keeps offering words
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++)
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    join
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(900);
    in_valid <= 1'b0;
    wait (expected_basis.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d angle words, checked %0d results, %0d degenerate", words_sent,
             words_checked, degen_seen);
    $display("covered field extremes, vertical pitch, bursty input and long output stalls");
    if (errors == 0 && expected_basis.size() == 0) begin
      $display("[euler_camera_basis_unit] OK");
    end else begin
      $display("[euler_camera_basis_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
